/* rtl/mds_pkg.sv */
// ----------------------------------------------------------------------------
// mds_pkg
// Types, widths and constants shared by the motor speed duty stepper modules.
// ----------------------------------------------------------------------------
package mds_pkg;

  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned SPC_W    = 8;
  localparam int unsigned DB_W     = 14;
  localparam int unsigned TARGET_W = 14;
  localparam int unsigned SPEED_W  = 24;
  localparam int unsigned STEP_W   = 18;
  localparam int unsigned DUTY_W   = 7;
  localparam int unsigned KEY_W    = 4;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 14;

  localparam logic [DUTY_W-1:0] DUTY_MIN = 7'd1;
  localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // Reciprocal of 100 for exact floor division of any 24-bit value.
  localparam int unsigned RECIP_W    = 25;
  localparam int unsigned STEP_SHIFT = 31;
  localparam logic [RECIP_W-1:0] STEP_RECIP = 25'd21474837;
  localparam int unsigned PROD_W = SPEED_W + RECIP_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_PER_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND        = 1'b1;

  localparam logic [SPC_W-1:0] SPC_RESET = 8'd60;
  localparam logic [DB_W-1:0]  DB_RESET  = 14'd500;

  typedef enum logic [KIND_W-1:0] {
    KIND_PULSE = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_KEY   = 2'd2
  } kind_e;

  typedef struct packed {
    logic              tick;
    logic              load;
    logic [DUTY_W-1:0] preset;
  } mds_op_t;

  typedef struct packed {
    mds_op_t             op;
    logic [SPEED_W-1:0]  meas;
    logic [TARGET_W-1:0] target;
  } mds_s1_t;

  typedef struct packed {
    mds_op_t            op;
    logic [SPEED_W-1:0] meas;
    logic [SPEED_W-1:0] diff;
    logic               up;
    logic               dn;
  } mds_s2_t;

  typedef struct packed {
    mds_op_t            op;
    logic [SPEED_W-1:0] meas;
    logic [STEP_W-1:0]  step;
    logic               up;
    logic               dn;
  } mds_s3_t;

  function automatic logic [DUTY_W-1:0] preset_duty(input logic [KEY_W-1:0] key);
    logic [DUTY_W-1:0] d;
    unique case (key)
      4'd1:    d = 7'd1;
      4'd2:    d = 7'd23;
      4'd3:    d = 7'd38;
      4'd4:    d = 7'd53;
      4'd5:    d = 7'd68;
      4'd6:    d = 7'd83;
      4'd7:    d = 7'd98;
      4'd8:    d = 7'd100;
      4'd9:    d = 7'd100;
      default: d = DUTY_MIN;
    endcase
    return d;
  endfunction

  function automatic logic [TARGET_W-1:0] preset_target(input logic [KEY_W-1:0] key);
    logic [TARGET_W-1:0] t;
    unique case (key)
      4'd2:    t = 14'd1500;
      4'd3:    t = 14'd3000;
      4'd4:    t = 14'd4500;
      4'd5:    t = 14'd6000;
      4'd6:    t = 14'd7500;
      4'd7:    t = 14'd9000;
      4'd8:    t = 14'd9500;
      4'd9:    t = 14'd9500;
      default: t = 14'd0;
    endcase
    return t;
  endfunction

endpackage

/* rtl/mds_front.sv */
// ----------------------------------------------------------------------------
// mds_front
// Pulse counter, target speed and the pulse-count-to-speed multiply.
// ----------------------------------------------------------------------------
module mds_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic [mds_pkg::KIND_W-1:0]     kind_i,
  input  logic [mds_pkg::KEY_W-1:0]      key_i,
  input  logic [mds_pkg::SPC_W-1:0]      spc_i,
  output mds_pkg::mds_s1_t               s1_o
);
  import mds_pkg::*;

  logic [COUNT_W-1:0]  count_q, count_d;
  logic [TARGET_W-1:0] target_q, target_d;
  mds_s1_t             s1_q, s1_d;
  logic                key_ok;

  assign key_ok = (key_i >= 4'd1) && (key_i <= 4'd9);

  always_comb begin
    count_d  = count_q;
    target_d = target_q;
    s1_d.op.tick   = 1'b0;
    s1_d.op.load   = 1'b0;
    s1_d.op.preset = preset_duty(key_i);
    s1_d.meas      = SPEED_W'(count_q) * SPEED_W'(spc_i);
    s1_d.target    = target_q;
    unique case (kind_i)
      KIND_PULSE: begin
        if (count_q != COUNT_MAX) count_d = count_q + 16'd1;
      end
      KIND_TICK: begin
        count_d      = '0;
        s1_d.op.tick = 1'b1;
      end
      KIND_KEY: begin
        if (key_ok) begin
          target_d     = preset_target(key_i);
          s1_d.op.load = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      target_q <= '0;
    end else if (en_i) begin
      count_q  <= count_d;
      target_q <= target_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) s1_q <= s1_d;
  end

  assign s1_o = s1_q;

endmodule

/* rtl/mds_err.sv */
// ----------------------------------------------------------------------------
// mds_err
// Absolute speed error and the deadband comparisons.
// ----------------------------------------------------------------------------
module mds_err (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  mds_pkg::mds_s1_t           s1_i,
  input  logic [mds_pkg::DB_W-1:0]   db_i,
  output mds_pkg::mds_s2_t           s2_o
);
  import mds_pkg::*;

  logic [SPEED_W-1:0] tgt;
  logic [SPEED_W-1:0] tgt_db;
  logic [SPEED_W:0]   meas_db;
  mds_s2_t            s2_q, s2_d;

  assign tgt     = SPEED_W'(s1_i.target);
  assign tgt_db  = tgt + SPEED_W'(db_i);
  assign meas_db = {1'b0, s1_i.meas} + (SPEED_W + 1)'(db_i);

  always_comb begin
    s2_d.op   = s1_i.op;
    s2_d.meas = s1_i.meas;
    s2_d.diff = (s1_i.meas >= tgt) ? (s1_i.meas - tgt) : (tgt - s1_i.meas);
    s2_d.up   = meas_db < {1'b0, tgt};
    s2_d.dn   = s1_i.meas > tgt_db;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) s2_q <= s2_d;
  end

  assign s2_o = s2_q;

endmodule

/* rtl/mds_div.sv */
// ----------------------------------------------------------------------------
// mds_div
// Step size: the speed error divided by 100 through a reciprocal multiply.
// ----------------------------------------------------------------------------
module mds_div (
  input  logic             clk_i,
  input  logic             en_i,
  input  mds_pkg::mds_s2_t s2_i,
  output mds_pkg::mds_s3_t s3_o
);
  import mds_pkg::*;

  logic [PROD_W-1:0] prod;
  mds_s3_t           s3_q, s3_d;

  assign prod = PROD_W'(s2_i.diff) * PROD_W'(STEP_RECIP);

  always_comb begin
    s3_d.op   = s2_i.op;
    s3_d.meas = s2_i.meas;
    s3_d.step = prod[STEP_SHIFT +: STEP_W];
    s3_d.up   = s2_i.up;
    s3_d.dn   = s2_i.dn;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) s3_q <= s3_d;
  end

  assign s3_o = s3_q;

endmodule

/* rtl/mds_duty.sv */
// ----------------------------------------------------------------------------
// mds_duty
// Duty update with clamping; its registers are both state and result.
// ----------------------------------------------------------------------------
module mds_duty (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  mds_pkg::mds_s3_t              s3_i,
  output logic [mds_pkg::DUTY_W-1:0]    duty_o,
  output logic [mds_pkg::SPEED_W-1:0]   speed_o,
  output logic [mds_pkg::STEP_W-1:0]    step_o
);
  import mds_pkg::*;

  logic [DUTY_W-1:0]  duty_q, duty_d;
  logic [SPEED_W-1:0] speed_q, speed_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [STEP_W:0]    sum;

  assign sum = (STEP_W + 1)'(duty_q) + (STEP_W + 1)'(s3_i.step);

  always_comb begin
    duty_d  = duty_q;
    speed_d = speed_q;
    step_d  = step_q;
    if (s3_i.op.tick) begin
      speed_d = s3_i.meas;
      step_d  = s3_i.step;
      if (s3_i.up) begin
        duty_d = (sum > (STEP_W + 1)'(DUTY_MAX)) ? DUTY_MAX : sum[DUTY_W-1:0];
      end else if (s3_i.dn) begin
        duty_d = (s3_i.step >= STEP_W'(duty_q)) ? DUTY_MIN
                                                : duty_q - s3_i.step[DUTY_W-1:0];
      end
    end else if (s3_i.op.load) begin
      duty_d = s3_i.op.preset;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q  <= DUTY_MIN;
      speed_q <= '0;
      step_q  <= '0;
    end else if (en_i) begin
      duty_q  <= duty_d;
      speed_q <= speed_d;
      step_q  <= step_d;
    end
  end

  assign duty_o  = duty_q;
  assign speed_o = speed_q;
  assign step_o  = step_q;

endmodule

/* rtl/motor_speed_duty_stepper_core.sv */
// ----------------------------------------------------------------------------
// motor_speed_duty_stepper_core
// Motor speed regulator: counts tachometer pulses, measures speed at each
// window tick and steps the PWM duty toward a keypad-selected target.
//
// Input stream: tuser carries the item kind (pulse, window tick, keypad key)
// and tdata carries the key number. Every accepted transaction produces one
// output transaction that shows the duty, the measured speed and the step
// size after that item.
// The item passes an input register, three processing stages and the result
// register. One transaction is accepted every cycle while the receiver
// takes results; the pulse counter and the duty register each close their
// update within their own stage.
// When the receiver stalls, the stages behind the result register keep
// filling, so up to four more transactions are accepted before tready falls.
// Reset clears the pipeline, the pulse count, target, speed and step, sets
// the duty to one percent and loads the register defaults (60 and 500).
// The configuration port writes a register in the cycle its enable is high.
// ----------------------------------------------------------------------------
module motor_speed_duty_stepper_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [7:0]                        s_axis_tdata_i,  // [3:0] key
  input  logic [mds_pkg::KIND_W-1:0]        s_axis_tuser_i,  // [1:0] kind
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [6:0] duty, [30:7] measured_speed, [48:31] step_size
  output logic [55:0]                       m_axis_tdata_o,
  input  logic                              cfg_we_i,
  input  logic [mds_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mds_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import mds_pkg::*;

  logic [SPC_W-1:0]  spc_q;
  logic [DB_W-1:0]   db_q;
  logic              v0_q, v1_q, v2_q, v3_q, vo_q;
  logic              adv0, adv1, adv2, adv3;
  logic              in_acc;
  logic [KIND_W-1:0] kind_q;
  logic [KEY_W-1:0]  key_q;
  mds_s1_t           s1;
  mds_s2_t           s2;
  mds_s3_t           s3;
  logic [DUTY_W-1:0]  duty;
  logic [SPEED_W-1:0] speed;
  logic [STEP_W-1:0]  step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spc_q <= SPC_RESET;
      db_q  <= DB_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SPEED_PER_COUNT: spc_q <= cfg_data_i[SPC_W-1:0];
        CFG_DEADBAND:        db_q  <= cfg_data_i[DB_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv3   = v3_q & (~vo_q | m_axis_tready_i);
  assign adv2   = v2_q & (~v3_q | adv3);
  assign adv1   = v1_q & (~v2_q | adv2);
  assign adv0   = v0_q & (~v1_q | adv1);
  assign s_axis_tready_o = ~v0_q | adv0;
  assign in_acc = s_axis_tvalid_i & s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) v0_q <= s_axis_tvalid_i;
      if (~v1_q | adv1)    v1_q <= adv0;
      if (~v2_q | adv2)    v2_q <= adv1;
      if (~v3_q | adv3)    v3_q <= adv2;
      if (~vo_q | m_axis_tready_i) vo_q <= adv3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= s_axis_tuser_i;
      key_q  <= s_axis_tdata_i[KEY_W-1:0];
    end
  end

  mds_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv0),
    .kind_i (kind_q),
    .key_i  (key_q),
    .spc_i  (spc_q),
    .s1_o   (s1)
  );

  mds_err u_err (
    .clk_i (clk_i),
    .en_i  (adv1),
    .s1_i  (s1),
    .db_i  (db_q),
    .s2_o  (s2)
  );

  mds_div u_div (
    .clk_i (clk_i),
    .en_i  (adv2),
    .s2_i  (s2),
    .s3_o  (s3)
  );

  mds_duty u_duty (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv3),
    .s3_i    (s3),
    .duty_o  (duty),
    .speed_o (speed),
    .step_o  (step)
  );

  assign m_axis_tvalid_o = vo_q;
  assign m_axis_tdata_o  = {7'b0, step, speed, duty};

  a_duty_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (duty >= DUTY_MIN) && (duty <= DUTY_MAX))
    else $error("duty left its range");

  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(v3_q))
    else $error("result appeared without an item in the last stage");

  a_stage_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !adv3) |=> v3_q)
    else $error("stalled item dropped from the last stage");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the motor speed duty stepper core. A driver feeds
// pulse, window tick and keypad transactions from a queue. A predictor keeps
// its own copy of the regulator state and computes the duty, measured speed
// and step size for every accepted input. A monitor compares each result
// transaction with the oldest prediction. The run covers several register
// settings, the deadband edges, a long pulse run at the highest speed per
// count and a long receiver stall under random backpressure on both sides.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mds_pkg::*;

  localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned HOLD_AT = 300;
  localparam int unsigned HOLD_BACKLOG = 16;
  localparam int unsigned SPEED_DIV = 100;
  localparam int unsigned PHASE_ITEMS = 160;
  localparam int unsigned LONG_RUN = 200;

  localparam logic [DUTY_W-1:0] KEY_DUTY [0:9] = '{
    7'd1, 7'd1, 7'd23, 7'd38, 7'd53, 7'd68, 7'd83, 7'd98, 7'd100, 7'd100
  };
  localparam logic [TARGET_W-1:0] KEY_TARGET [0:9] = '{
    14'd0, 14'd0, 14'd1500, 14'd3000, 14'd4500, 14'd6000, 14'd7500, 14'd9000,
    14'd9500, 14'd9500
  };

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
  } motor_event_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic [SPEED_W-1:0] speed;
    logic [STEP_W-1:0]  step;
  } motor_reading_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [7:0]            s_data = '0;
  logic [KIND_W-1:0]     s_user = '0;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [55:0]           m_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  motor_event_t   pending_events[$];
  motor_reading_t expected_readings[$];

  logic [COUNT_W-1:0]  pulse_tally = '0;
  logic [SPEED_W-1:0]  speed_now = '0;
  logic [DUTY_W-1:0]   duty_now = DUTY_MIN;
  logic [TARGET_W-1:0] target_now = '0;
  logic [STEP_W-1:0]   step_now = '0;
  logic [SPC_W-1:0]    spc_now = SPC_RESET;
  logic [DB_W-1:0]     deadband_now = DB_RESET;

  int unsigned gen_target = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_no = 0;
  int unsigned idle_run = 0;
  int unsigned readings_seen = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        calm;

  assign calm = (cycle_no >= 900) && (cycle_no < 1200);

  motor_speed_duty_stepper_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic motor_reading_t advance_regulator(input motor_event_t ev);
    int unsigned gap, spd, tgt, band;
    int duty_acc;
    case (ev.kind)
      KIND_PULSE: begin
        if (pulse_tally != COUNT_MAX) pulse_tally = pulse_tally + 1'b1;
      end
      KIND_TICK: begin
        speed_now = SPEED_W'(pulse_tally) * SPEED_W'(spc_now);
        pulse_tally = '0;
        spd = speed_now;
        tgt = target_now;
        band = deadband_now;
        gap = (spd >= tgt) ? spd - tgt : tgt - spd;
        step_now = STEP_W'(gap / SPEED_DIV);
        duty_acc = int'(duty_now);
        if (spd + band < tgt) duty_acc += int'(step_now);
        else if (spd > tgt + band) duty_acc -= int'(step_now);
        if (duty_acc < int'(DUTY_MIN)) duty_acc = int'(DUTY_MIN);
        if (duty_acc > int'(DUTY_MAX)) duty_acc = int'(DUTY_MAX);
        duty_now = DUTY_W'(duty_acc);
      end
      KIND_KEY: begin
        if (ev.key >= 1 && ev.key <= 9) begin
          duty_now = KEY_DUTY[ev.key];
          target_now = KEY_TARGET[ev.key];
        end
      end
      default: ;
    endcase
    return '{duty: duty_now, speed: speed_now, step: step_now};
  endfunction

  task automatic queue_event(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
    pending_events.push_back('{kind: kind, key: key});
    if (kind == KIND_KEY && key >= 1 && key <= 9) gen_target = KEY_TARGET[key];
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_events.size() != 0 || s_valid || expected_readings.size() != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_SPEED_PER_COUNT) spc_now = SPC_W'(value);
    else deadband_now = DB_W'(value);
  endtask

  // Mostly pulse runs closed by a window tick, sized so that the measured speed
  // spans the target range or lands right at the deadband edges, with preset keys and
  // ignored items mixed in.
  task automatic queue_random(input int unsigned count);
    int unsigned made, np, lim, edge_speed;
    int guess;
    made = 0;
    @(negedge clk_i);
    while (made < count) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          queue_event(KIND_KEY, KEY_W'($urandom_range(1, 9)));
          made++;
        end
        2: queue_event(KIND_IGNORED, KEY_W'($urandom_range(0, 15)));
        3: queue_event(KIND_KEY, $urandom_range(0, 1) ? 4'd0 : KEY_W'($urandom_range(10, 15)));
        default: begin
          np = $urandom_range(0, 8);
          if (spc_now != 0 && $urandom_range(0, 2) != 0) begin
            if ($urandom_range(0, 1)) begin
              lim = 12000 / spc_now;
              if (lim > 200) lim = 200;
              np = $urandom_range(0, lim);
            end else begin
              if ($urandom_range(0, 1)) edge_speed = gen_target + deadband_now;
              else if (gen_target >= deadband_now) edge_speed = gen_target - deadband_now;
              else edge_speed = 0;
              guess = int'(edge_speed / spc_now) + int'($urandom_range(0, 2)) - 1;
              if (guess >= 0 && guess <= 300) np = guess;
            end
          end
          repeat (np) queue_event(KIND_PULSE, KEY_W'($urandom_range(0, 15)));
          queue_event(KIND_TICK, KEY_W'($urandom_range(0, 15)));
          made += np + 1;
        end
      endcase
    end
  endtask

  task automatic run_phase(input int unsigned spc, input int unsigned band);
    wait_idle();
    write_reg(CFG_SPEED_PER_COUNT, spc);
    write_reg(CFG_DEADBAND, band);
    queue_random(PHASE_ITEMS);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : driver
    motor_event_t ev;
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_user <= KIND_PULSE;
      s_data <= '0;
    end else if (!s_valid || s_ready) begin
      if (pending_events.size() != 0 && (calm || $urandom_range(0, 99) >= 12)) begin
        ev = pending_events.pop_front();
        s_valid <= 1'b1;
        s_user <= ev.kind;
        s_data <= {4'b0000, ev.key};
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    motor_reading_t want;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (s_valid && s_ready) begin
        expected_readings.push_back(advance_regulator('{kind: s_user, key: s_data[KEY_W-1:0]}));
      end
      if (m_valid && m_ready) begin
        readings_seen <= readings_seen + 1;
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected transaction, duty %0d speed %0d step %0d", $time,
                   m_data[6:0], m_data[30:7], m_data[48:31]);
          fail_count++;
        end else begin
          want = expected_readings.pop_front();
          if (m_data[6:0] !== want.duty) begin
            $display("%0t: duty expected %0d actual %0d", $time, want.duty, m_data[6:0]);
            fail_count++;
          end
          if (m_data[30:7] !== want.speed) begin
            $display("%0t: measured speed expected %0d actual %0d", $time, want.speed,
                     m_data[30:7]);
            fail_count++;
          end
          if (m_data[48:31] !== want.step) begin
            $display("%0t: step size expected %0d actual %0d", $time, want.step,
                     m_data[48:31]);
            fail_count++;
          end
        end
      end
      if (hold_left != 0) begin
        m_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && readings_seen >= HOLD_AT &&
                   pending_events.size() >= HOLD_BACKLOG) begin
        m_ready <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        m_ready <= calm || ($urandom_range(0, 99) >= 12);
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (rst_ni) begin
      cycle_no <= cycle_no + 1;
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle_run <= 0;
      end else if (idle_run >= STALL_LIMIT) begin
        $display("testbench failed");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    queue_event(KIND_IGNORED, 4'd15);
    queue_event(KIND_KEY, 4'd0);
    queue_event(KIND_KEY, 4'd10);
    queue_event(KIND_KEY, 4'd15);
    queue_event(KIND_TICK, 4'd0);
    queue_event(KIND_KEY, 4'd8);
    queue_event(KIND_TICK, 4'd5);
    for (int k = 2; k <= 7; k++) queue_event(KIND_KEY, KEY_W'(k));
    queue_event(KIND_KEY, 4'd9);
    queue_event(KIND_TICK, 4'd10);
    queue_event(KIND_KEY, 4'd1);
    for (int k = 0; k < 9; k++) queue_event(KIND_PULSE, KEY_W'(k * 7));
    queue_event(KIND_TICK, 4'd3);
    queue_random(PHASE_ITEMS);

    run_phase(255, 0);
    run_phase(100, 500);
    run_phase(1, 16383);
    run_phase(0, 37);
    run_phase(200, 8191);

    // A long pulse run at the highest speed per count, then a full-speed target.
    wait_idle();
    write_reg(CFG_SPEED_PER_COUNT, 255);
    write_reg(CFG_DEADBAND, 1200);
    @(negedge clk_i);
    queue_event(KIND_KEY, 4'd1);
    repeat (LONG_RUN) queue_event(KIND_PULSE, KEY_W'($urandom_range(0, 15)));
    queue_event(KIND_TICK, KEY_W'($urandom_range(0, 15)));
    queue_event(KIND_KEY, 4'd8);
    queue_event(KIND_TICK, 4'd0);

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && expected_readings.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/mds_pkg.sv
rtl/mds_front.sv
rtl/mds_err.sv
rtl/mds_div.sv
rtl/mds_duty.sv
rtl/motor_speed_duty_stepper_core.sv
tb/testbench.sv
